@@ hw/rtl/adaptive_reversal_deadband_filter_macros.svh @@
`ifndef ADAPTIVE_REVERSAL_DEADBAND_FILTER_MACROS_SVH
`define ADAPTIVE_REVERSAL_DEADBAND_FILTER_MACROS_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define ARDF_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define ARDF_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hw/rtl/ardf_pkg.sv @@
package ardf_pkg;

	localparam int SAMPLE_BITS = 24;

	localparam int WEIGHT_W   = 17;
	localparam int MULT_W     = 16;
	localparam int INIT_W     = 23;
	localparam int CFG_DATA_W = 23;
	localparam int CFG_IDX_W  = 2;

	localparam int WIDTH_W   = SAMPLE_BITS - 1;
	localparam int BAND_W    = SAMPLE_BITS + 2;
	localparam int PROD_W    = WEIGHT_W + SAMPLE_BITS;
	localparam int SUM_W     = PROD_W + 1;
	localparam int WPROD_W   = SAMPLE_BITS + MULT_W;
	localparam int WSUM_W    = WPROD_W + 1;
	localparam int CLAMP_W   = WSUM_W - 8;

	localparam logic [CFG_IDX_W-1:0] REG_EMA_WEIGHT   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BAND_MULT    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_INITIAL_BAND = 2'd2;

	localparam logic [WEIGHT_W-1:0] Q16_ONE        = 17'h10000;
	localparam logic [WEIGHT_W-1:0] EMA_WEIGHT_RST = 17'd6554;
	localparam logic [MULT_W-1:0]   BAND_MULT_RST  = 16'd512;
	localparam logic [WIDTH_W-1:0]  BAND_WIDTH_RST = '0;

	localparam logic [WIDTH_W-1:0] WIDTH_MAX = '1;
	localparam logic signed [BAND_W-1:0] MID_MAX =
		{{(BAND_W-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
	localparam logic signed [BAND_W-1:0] MID_MIN =
		{{(BAND_W-SAMPLE_BITS+1){1'b1}}, {(SAMPLE_BITS-1){1'b0}}};

	typedef enum logic [1:0] {
		DIR_NONE = 2'd0,
		DIR_UP   = 2'd1,
		DIR_DOWN = 2'd2
	} dir_t;

	typedef struct packed {
		logic capture;
		logic ema_mul;
		logic ema_set;
		logic wid_mul;
		logic wid_set;
		logic finish;
	} ardf_cmd_t;

	typedef struct packed {
		logic primed;
		logic ema_path;
	} ardf_status_t;

	function automatic logic [WIDTH_W-1:0] clamp_width(input logic [CLAMP_W-1:0] w);
		if (w > CLAMP_W'(WIDTH_MAX))
			return WIDTH_MAX;
		return w[WIDTH_W-1:0];
	endfunction

endpackage

@@ hw/rtl/ardf_ctrl.sv @@
module ardf_ctrl (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	output logic                    out_valid,
	input  logic                    out_ready,
	input  ardf_pkg::ardf_status_t  status,
	output ardf_pkg::ardf_cmd_t     cmd
);
	import ardf_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EVAL,
		ST_EMA_MUL,
		ST_EMA_SET,
		ST_WID_MUL,
		ST_WID_SET,
		ST_FINISH
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = ST_EVAL;
				end
			end
			ST_EVAL: begin
				if (status.primed && status.ema_path)
					state_d = ST_EMA_MUL;
				else
					state_d = ST_FINISH;
			end
			ST_EMA_MUL: begin
				cmd.ema_mul = 1'b1;
				state_d     = ST_EMA_SET;
			end
			ST_EMA_SET: begin
				cmd.ema_set = 1'b1;
				state_d     = ST_WID_MUL;
			end
			ST_WID_MUL: begin
				cmd.wid_mul = 1'b1;
				state_d     = ST_WID_SET;
			end
			ST_WID_SET: begin
				cmd.wid_set = 1'b1;
				state_d     = ST_FINISH;
			end
			ST_FINISH: begin
				// hold until the output register is free
				if (!out_valid_q || out_ready) begin
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.finish)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

endmodule

@@ hw/rtl/ardf_dp.sv @@
module ardf_dp (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_wr_en,
	input  logic [ardf_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [ardf_pkg::CFG_DATA_W-1:0]       cfg_data,
	input  logic signed [ardf_pkg::SAMPLE_BITS-1:0] sample,
	input  ardf_pkg::ardf_cmd_t                   cmd,
	output ardf_pkg::ardf_status_t                status,
	output logic signed [ardf_pkg::SAMPLE_BITS-1:0] filtered
);
	import ardf_pkg::*;

	localparam int SB = SAMPLE_BITS;

	logic [WEIGHT_W-1:0]      weight_q;
	logic [MULT_W-1:0]        mult_q;
	logic                     primed_q;
	logic signed [BAND_W-1:0] top_q;
	logic signed [BAND_W-1:0] bottom_q;
	logic [WIDTH_W-1:0]       width_q;
	logic [SB-1:0]            ema_q;
	logic signed [SB-1:0]     last_q;
	dir_t                     dir_q;
	logic                     seen_q;
	logic signed [SB-1:0]     rpoint_q;
	logic signed [SB-1:0]     x_q;
	logic [PROD_W-1:0]        pa_q;
	logic [PROD_W-1:0]        pb_q;
	logic [WPROD_W-1:0]       wprod_q;
	logic signed [SB-1:0]     filtered_q;

	dir_t                     trend;
	logic                     reversed;
	logic signed [SB:0]       delta;
	logic signed [SB:0]       delta_neg;
	logic [SB-1:0]            diff;
	logic [WEIGHT_W-1:0]      a_sat;
	logic [WEIGHT_W-1:0]      a_inv;
	logic [SUM_W-1:0]         ema_sum;
	logic [SB-1:0]            ema_new;
	logic [WSUM_W-1:0]        wsum;
	logic signed [BAND_W-1:0] xb;
	logic signed [BAND_W-1:0] wb;
	logic signed [BAND_W-1:0] half;
	logic signed [BAND_W-1:0] top_n;
	logic signed [BAND_W-1:0] bot_n;
	logic signed [BAND_W:0]   mid_sum;
	logic signed [BAND_W-1:0] mid;
	logic signed [SB-1:0]     mid_sat;

	always_comb begin
		if (x_q > last_q)
			trend = DIR_UP;
		else if (x_q < last_q)
			trend = DIR_DOWN;
		else
			trend = DIR_NONE;
	end

	assign reversed = (dir_q != DIR_NONE) && (trend != DIR_NONE) && (dir_q != trend);

	assign status.primed   = primed_q;
	assign status.ema_path = reversed && seen_q;

	assign delta     = {x_q[SB-1], x_q} - {rpoint_q[SB-1], rpoint_q};
	assign delta_neg = -delta;
	assign diff      = delta[SB] ? delta_neg[SB-1:0] : delta[SB-1:0];

	assign a_sat = (weight_q > Q16_ONE) ? Q16_ONE : weight_q;
	assign a_inv = Q16_ONE - a_sat;

	// weighted sum rounded half up; seed straight from the distance while empty
	assign ema_sum = {1'b0, pa_q} + {1'b0, pb_q} + SUM_W'(32768);
	assign ema_new = (ema_q == '0) ? diff : ema_sum[16 +: SB];

	assign wsum = {1'b0, wprod_q} + WSUM_W'(128);

	assign xb   = {{(BAND_W-SB){x_q[SB-1]}}, x_q};
	assign wb   = {{(BAND_W-WIDTH_W){1'b0}}, width_q};
	assign half = {{(BAND_W-WIDTH_W+1){1'b0}}, width_q[WIDTH_W-1:1]};

	always_comb begin
		top_n = top_q;
		bot_n = bottom_q;
		if (!primed_q) begin
			top_n = xb + half;
			bot_n = xb - half;
		end else if (xb > top_q) begin
			top_n = xb;
			bot_n = xb - wb;
		end else if (xb < bottom_q) begin
			bot_n = xb;
			top_n = xb + wb;
		end
	end

	assign mid_sum = {top_n[BAND_W-1], top_n} + {bot_n[BAND_W-1], bot_n};
	assign mid     = mid_sum[BAND_W:1];

	always_comb begin
		if (mid > MID_MAX)
			mid_sat = MID_MAX[SB-1:0];
		else if (mid < MID_MIN)
			mid_sat = MID_MIN[SB-1:0];
		else
			mid_sat = mid[SB-1:0];
	end

	assign filtered = filtered_q;

	// unreset working registers
	always_ff @(posedge clk) begin
		if (cmd.capture)
			x_q <= sample;
		if (cmd.ema_mul) begin
			pa_q <= PROD_W'(a_sat) * PROD_W'(diff);
			pb_q <= PROD_W'(a_inv) * PROD_W'(ema_q);
		end
		if (cmd.wid_mul)
			wprod_q <= WPROD_W'(ema_q) * WPROD_W'(mult_q);
		if (cmd.finish)
			filtered_q <= mid_sat;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			weight_q <= EMA_WEIGHT_RST;
			mult_q   <= BAND_MULT_RST;
			primed_q <= 1'b0;
			top_q    <= '0;
			bottom_q <= '0;
			width_q  <= BAND_WIDTH_RST;
			ema_q    <= '0;
			last_q   <= '0;
			dir_q    <= DIR_NONE;
			seen_q   <= 1'b0;
			rpoint_q <= '0;
		end else begin
			if (cfg_wr_en) begin
				unique case (cfg_index)
					REG_EMA_WEIGHT:   weight_q <= cfg_data[WEIGHT_W-1:0];
					REG_BAND_MULT:    mult_q   <= cfg_data[MULT_W-1:0];
					REG_INITIAL_BAND: begin
						if (ema_q == '0)
							width_q <= clamp_width(CLAMP_W'(cfg_data[INIT_W-1:0]));
					end
					default: ;
				endcase
			end
			if (cmd.ema_set)
				ema_q <= ema_new;
			if (cmd.wid_set)
				width_q <= clamp_width(wsum[WSUM_W-1:8]);
			if (cmd.finish) begin
				top_q    <= top_n;
				bottom_q <= bot_n;
				last_q   <= x_q;
				primed_q <= 1'b1;
				if (!primed_q) begin
					dir_q <= DIR_NONE;
				end else begin
					dir_q <= trend;
					if (reversed) begin
						seen_q   <= 1'b1;
						rpoint_q <= x_q;
					end else begin
						seen_q <= 1'b0;
					end
				end
			end
		end
	end

endmodule

@@ hw/rtl/adaptive_reversal_deadband_filter.sv @@
// Adaptive reversal deadband filter.
// Input channel: in_valid/in_ready with one signed sample per beat.
// Output channel: out_valid/out_ready with one filtered value per beat, the
// midpoint of a deadband that moves only when a sample falls outside it.
// Configuration: cfg_wr_en/cfg_index/cfg_data, to be written only while idle;
// the block itself does not enforce this. Index 0 EMA weight (Q1.16),
// 1 band multiplier (Q8.8), 2 initial band.
// Timing: a beat is taken in the idle cycle, an evaluate step follows, and
// the result is loaded into the output register on the finish cycle. A sample
// that completes a reversal pair also passes through the EMA multiply and sum
// and the band-width multiply and clamp, which share the controller's
// sequence, between evaluate and finish. out_valid rises at the finish edge.
// One sample is in work at a time; in_ready is high only in the idle state.
// The output register lets the next sample be taken while a result waits.
// Stall: if out_ready stays low, the finished result holds and the next
// sample waits in the finish step until the output register is free.
// Reset: arst_n clears the band, trend tracking and EMA, and loads the
// configuration registers with their default values.
module adaptive_reversal_deadband_filter (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic signed [ardf_pkg::SAMPLE_BITS-1:0] sample,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic signed [ardf_pkg::SAMPLE_BITS-1:0] filtered,
	input  logic                                  cfg_wr_en,
	input  logic [ardf_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [ardf_pkg::CFG_DATA_W-1:0]       cfg_data
);
	import ardf_pkg::*;

	ardf_cmd_t    cmd;
	ardf_status_t status;

	ardf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd)
	);

	ardf_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.sample    (sample),
		.cmd       (cmd),
		.status    (status),
		.filtered  (filtered)
	);

endmodule

@@ hw/rtl/ardf_checker.sv @@
`include "adaptive_reversal_deadband_filter_macros.svh"

module ardf_checker (
	input logic                                  clk,
	input logic                                  arst_n,
	input logic                                  in_valid,
	input logic                                  in_ready,
	input logic                                  out_valid,
	input logic                                  out_ready,
	input logic signed [ardf_pkg::SAMPLE_BITS-1:0] filtered
);
	import ardf_pkg::*;

	// a stalled result holds its value
	`ARDF_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(filtered), "stalled output beat changed")

	// one sample in work at a time
	`ARDF_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "input accepted while busy")

	// a new result only comes out of a busy cycle
	`ARDF_ASSERT_SAME(a_result_from_work, $rose(out_valid), !$past(in_ready), "result without work")

endmodule

bind adaptive_reversal_deadband_filter ardf_checker u_ardf_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.filtered  (filtered)
);
